>>> rtl/spec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// types and fixed codes for the scaled polynomial evaluator with clipping
// no dependencies; imported by scaled_poly_eval_clip

package spec_pkg;

	localparam int VALUE_W   = 32;
	localparam int CFG_W     = 31;
	localparam int CFG_IDX_W = 2;
	localparam int INDEX_W   = 4;
	localparam int DEGREE_W  = 4;
	localparam int MODE_W    = 2;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_DEGREE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLIP_MODE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEVEL = 2'd2;

	// clip modes, anything else means no clipping
	localparam logic [MODE_W-1:0] CLIP_NONE = 2'd0;
	localparam logic [MODE_W-1:0] CLIP_HARD = 2'd1;
	localparam logic [MODE_W-1:0] CLIP_SOFT = 2'd2;

	// word kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_EVAL = 1'b1;

	// symmetric saturation bound of the 64-bit intermediates
	localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef enum logic [12:0] {
		S_IDLE = 13'b0_0000_0000_0001,
		S_RD0  = 13'b0_0000_0000_0010,
		S_INIT = 13'b0_0000_0000_0100,
		S_MSET = 13'b0_0000_0000_1000,
		S_MLO  = 13'b0_0000_0001_0000,
		S_MHI  = 13'b0_0000_0010_0000,
		S_MFIN = 13'b0_0000_0100_0000,
		S_ADD  = 13'b0_0000_1000_0000,
		S_SAT  = 13'b0_0001_0000_0000,
		S_CLIP = 13'b0_0010_0000_0000,
		S_DMUL = 13'b0_0100_0000_0000,
		S_DIV  = 13'b0_1000_0000_0000,
		S_DONE = 13'b1_0000_0000_0000
	} state_t;

	// which product of a degree step the multiplier is working on
	typedef enum logic [1:0] {
		OP_TX = 2'd0,	// term * x
		OP_TR = 2'd1,	// (term * x) * recip(i)
		OP_CT = 2'd2	// coef[i] * term
	} op_t;

endpackage

`default_nettype wire

>>> rtl/scaled_poly_eval_clip.sv
`timescale 1ns / 1ps
`default_nettype none
// scaled polynomial evaluator: sum of c[i]*x^i/i!, saturation and clipping
// depends on spec_pkg
//
// usage
//  in channel (in_valid/in_ready): kind, coef_index, value. a load word writes
//  value into coefficient slot coef_index and gives no result; an
//  evaluate word takes value as x and gives one result word
//  out channel (out_valid/out_ready): result and saturated, held in an output
//  register; the sequencer may finish the next item while a word waits there
//  cfg port: cfg_we, cfg_index, cfg_data; degree, clip_mode, clip_level
//  timing: one item at a time. soft clipping adds one multiply and a 31-step
//  restoring divider. each degree step does three 64-by-32 products on one
//  shared 32x32 multiplier, each through states MSET, MLO, MHI and MFIN,
//  then an add
//  coefficients sit in a synchronous memory whose registered read is issued ahead of use
//  reset: clears control registers, marks all slots unwritten (read as zero)
//  stall: with the output register full the sequencer holds its finished value
//  and does not take a new word until the register drains

module scaled_poly_eval_clip #(
	parameter int MAX_COEFS = 16,
	parameter int FRAC_BITS = 16
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire                                 kind,
	input  wire  [spec_pkg::INDEX_W-1:0]        coef_index,
	input  wire  signed [spec_pkg::VALUE_W-1:0] value,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic signed [spec_pkg::VALUE_W-1:0] result,
	output logic                                saturated,
	input  wire                                 cfg_we,
	input  wire  [spec_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [spec_pkg::CFG_W-1:0]          cfg_data
);
	import spec_pkg::*;

	localparam int IDX_W = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1;
	localparam int unsigned ONE_R = 1 << FRAC_BITS;
	localparam logic [63:0] ONE = 64'(ONE_R);
	localparam logic signed [64:0] SAT_HI = {1'b0, SAT_MAX};
	localparam logic signed [64:0] SAT_LO = -SAT_HI;

	// floor(2^FRAC_BITS / i), slot zero unused
	localparam logic [31:0] RECIP_TAB [16] = '{
		32'd0,            32'(ONE_R / 1),  32'(ONE_R / 2),  32'(ONE_R / 3),
		32'(ONE_R / 4),   32'(ONE_R / 5),  32'(ONE_R / 6),  32'(ONE_R / 7),
		32'(ONE_R / 8),   32'(ONE_R / 9),  32'(ONE_R / 10), 32'(ONE_R / 11),
		32'(ONE_R / 12),  32'(ONE_R / 13), 32'(ONE_R / 14), 32'(ONE_R / 15)
	};

	// configuration
	logic [DEGREE_W-1:0] degree_q;
	logic [MODE_W-1:0]   clip_mode_q;
	logic [CFG_W-1:0]    clip_level_q;

	// control
	state_t              state_q, state_d;
	op_t                 op_q;
	logic [DEGREE_W-1:0] i_q;
	logic [4:0]          cnt_q;
	logic                out_valid_q;
	logic [MAX_COEFS-1:0] valid_q;

	// coefficient memory
	logic [VALUE_W-1:0] mem [MAX_COEFS];
	logic [VALUE_W-1:0] rd_data_q;
	logic               rd_valid_q;

	// datapath
	logic signed [63:0] term_q, sum_q, prod_q;
	logic [63:0]        mag_a_q, pp_lo_q, pp_hi_q;
	logic [31:0]        mag_b_q, ares_q;
	logic               neg_q, sat_q;
	logic signed [31:0] x_q, res_q, fin_q;
	logic [61:0]        dsh_q;
	logic [30:0]        quo_q;
	logic signed [31:0] result_q;
	logic               saturated_q;

	// combinational
	logic                accept, load_we, out_load;
	logic [DEGREE_W-1:0] deg_lim;
	logic [IDX_W-1:0]    waddr, raddr;
	logic [31:0]         coef_c;
	logic signed [63:0]  a_sel;
	logic signed [32:0]  b_sel;
	logic [63:0]         mag_a;
	logic [31:0]         mag_b;
	logic [31:0]         mul_a, mul_b;
	logic [63:0]         mul_p;
	logic [95:0]         full, qf;
	logic                fx_sat;
	logic [63:0]         fx_mag;
	logic signed [63:0]  fx_res;
	logic signed [64:0]  sum65;
	logic signed [63:0]  sum_sat;
	logic                sum_ovf;
	logic signed [31:0]  sat_res;
	logic signed [31:0]  lvl_s, clip_val;
	logic [31:0]         dvs;
	logic                div_ge;
	logic [30:0]         quo_nx;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign load_we  = accept && (kind == KIND_LOAD) && (32'(coef_index) < MAX_COEFS);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// degree limited to the store depth
	assign deg_lim = (32'(degree_q) > MAX_COEFS - 1) ? DEGREE_W'(MAX_COEFS - 1) : degree_q;

	assign waddr  = IDX_W'(coef_index);
	assign raddr  = IDX_W'(i_q);
	assign coef_c = rd_valid_q ? rd_data_q : '0;

	// operand selection for the 64-by-32 fixed-point product
	always_comb begin
		case (op_q)
			OP_TR: begin
				a_sel = prod_q;
				b_sel = {1'b0, RECIP_TAB[i_q]};
			end
			OP_CT: begin
				a_sel = term_q;
				b_sel = {coef_c[31], coef_c};
			end
			default: begin
				a_sel = term_q;
				b_sel = {x_q[31], x_q};
			end
		endcase
	end

	assign mag_a = a_sel[63] ? 64'(-a_sel) : 64'(a_sel);
	assign mag_b = b_sel[32] ? 32'(-b_sel) : 32'(b_sel);

	// the one multiplier: low half, high half, or soft clip numerator
	always_comb begin
		mul_a = ares_q;
		mul_b = {1'b0, clip_level_q};
		if (state_q == S_MLO) begin
			mul_a = mag_a_q[31:0];
			mul_b = mag_b_q;
		end else if (state_q == S_MHI) begin
			mul_a = mag_a_q[63:32];
			mul_b = mag_b_q;
		end
	end
	assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

	// reassemble, drop fraction bits, saturate, apply sign
	assign full   = {pp_hi_q, 32'b0} + {32'b0, pp_lo_q};
	assign qf     = full >> FRAC_BITS;
	assign fx_sat = |qf[95:63];
	assign fx_mag = fx_sat ? SAT_MAX : {1'b0, qf[62:0]};
	assign fx_res = neg_q ? -$signed(fx_mag) : $signed(fx_mag);

	// saturating accumulate
	assign sum65   = {sum_q[63], sum_q} + {prod_q[63], prod_q};
	always_comb begin
		if (sum65 > SAT_HI)
			sum_sat = SAT_MAX;
		else if (sum65 < SAT_LO)
			sum_sat = 64'(SAT_LO);
		else
			sum_sat = sum65[63:0];
	end

	// 64-bit sum to the 32-bit output range
	assign sum_ovf = (sum_q[63:31] != {33{sum_q[63]}});
	assign sat_res = sum_ovf ? (sum_q[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : sum_q[31:0];

	// hard clip, or pass-through; soft clip with a zero divisor gives zero
	assign lvl_s = $signed({1'b0, clip_level_q});
	assign dvs   = {1'b0, clip_level_q} + ares_q;
	always_comb begin
		case (clip_mode_q)
			CLIP_HARD: begin
				if (res_q >= lvl_s)
					clip_val = lvl_s;
				else if (res_q <= -lvl_s)
					clip_val = -lvl_s;
				else
					clip_val = res_q;
			end
			CLIP_SOFT: clip_val = '0;
			default:   clip_val = res_q;
		endcase
	end

	// one restoring step per cycle, divisor shifts right
	assign div_ge = (pp_lo_q[61:0] >= dsh_q);
	assign quo_nx = {quo_q[29:0], div_ge};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (accept && kind == KIND_EVAL) state_d = S_RD0;
			S_RD0:  state_d = S_INIT;
			S_INIT: state_d = (deg_lim == '0) ? S_SAT : S_MSET;
			S_MSET: state_d = S_MLO;
			S_MLO:  state_d = S_MHI;
			S_MHI:  state_d = S_MFIN;
			S_MFIN: state_d = (op_q == OP_CT) ? S_ADD : S_MSET;
			S_ADD:  state_d = (i_q == deg_lim) ? S_SAT : S_MSET;
			S_SAT:  state_d = S_CLIP;
			S_CLIP: state_d = (clip_mode_q == CLIP_SOFT && dvs != '0) ? S_DMUL : S_DONE;
			S_DMUL: state_d = S_DIV;
			S_DIV:  state_d = (cnt_q == '0) ? S_DONE : S_DIV;
			S_DONE: if (out_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_TX;
			i_q          <= '0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
			valid_q      <= '0;
			degree_q     <= '0;
			clip_mode_q  <= CLIP_NONE;
			clip_level_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_DEGREE:     degree_q     <= cfg_data[DEGREE_W-1:0];
					CFG_CLIP_MODE:  clip_mode_q  <= cfg_data[MODE_W-1:0];
					CFG_CLIP_LEVEL: clip_level_q <= cfg_data;
					default:        ;
				endcase
			end
			if (load_we)
				valid_q[waddr] <= 1'b1;
			if (accept)
				i_q <= '0;
			case (state_q)
				S_INIT: begin
					i_q  <= DEGREE_W'(1);
					op_q <= OP_TX;
				end
				S_MFIN: begin
					if (op_q == OP_TX)
						op_q <= OP_TR;
					else if (op_q == OP_TR)
						op_q <= OP_CT;
				end
				S_ADD: begin
					if (i_q != deg_lim) begin
						i_q  <= i_q + DEGREE_W'(1);
						op_q <= OP_TX;
					end
				end
				S_DMUL: cnt_q <= 5'd30;
				S_DIV:  if (cnt_q != '0) cnt_q <= cnt_q - 5'd1;
				default: ;
			endcase
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// coefficient memory, registered read of slot i
	always_ff @(posedge clk) begin
		if (load_we)
			mem[waddr] <= value;
		rd_data_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rd_valid_q <= 1'b0;
		else
			rd_valid_q <= valid_q[raddr];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept)
			x_q <= value;
		case (state_q)
			S_INIT: begin
				term_q <= $signed(ONE);
				sum_q  <= {{32{coef_c[31]}}, coef_c};
			end
			S_MSET: begin
				mag_a_q <= mag_a;
				mag_b_q <= mag_b;
				neg_q   <= a_sel[63] ^ b_sel[32];
			end
			S_MLO: pp_lo_q <= mul_p;
			S_MHI: pp_hi_q <= mul_p;
			S_MFIN: begin
				if (op_q == OP_TR)
					term_q <= fx_res;
				else
					prod_q <= fx_res;
			end
			S_ADD: sum_q <= sum_sat;
			S_SAT: begin
				res_q  <= sat_res;
				sat_q  <= sum_ovf;
				ares_q <= sat_res[31] ? 32'(-sat_res) : 32'(sat_res);
			end
			S_CLIP: begin
				fin_q <= clip_val;
				dsh_q <= {dvs, 30'b0};
				quo_q <= '0;
			end
			S_DMUL: pp_lo_q <= mul_p;
			S_DIV: begin
				if (div_ge)
					pp_lo_q <= pp_lo_q - {2'b0, dsh_q};
				dsh_q <= dsh_q >> 1;
				quo_q <= quo_nx;
				if (cnt_q == '0)
					fin_q <= res_q[31] ? -$signed({1'b0, quo_nx}) : $signed({1'b0, quo_nx});
			end
			default: ;
		endcase
		if (out_load) begin
			result_q    <= fin_q;
			saturated_q <= sat_q;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;
	assign saturated = saturated_q;

endmodule

`default_nettype wire

>>> dv/scaled_poly_eval_clip_tb.sv
`timescale 1ns / 1ps
// self-checking bench for scaled_poly_eval_clip: loads, evaluations, clip modes
// depends on spec_pkg and the scaled_poly_eval_clip rtl

module scaled_poly_eval_clip_tb;
	import spec_pkg::*;

	localparam int FRAC_BITS   = 16;
	localparam int SETTLE      = 240;	// longest evaluation: degree 15 plus soft clip
	localparam int CYCLE_LIMIT = 1_000_000;

	// clip mode code that the block treats as no clipping
	localparam logic [MODE_W-1:0] CLIP_UNUSED = 2'd3;

	// symmetric bound of the 64-bit intermediates, signed views
	localparam logic signed [63:0] BOUND   = $signed(SAT_MAX);
	localparam logic signed [64:0] BOUND65 = $signed({1'b0, SAT_MAX});
	localparam logic signed [63:0] I32_HI  = 64'sd2147483647;
	localparam logic signed [63:0] I32_LO  = -64'sd2147483648;

	typedef struct packed {
		logic               k;
		logic [INDEX_W-1:0] idx;
		logic [VALUE_W-1:0] v;
	} word_t;

	typedef struct packed {
		logic [VALUE_W-1:0] res;
		logic               sat;
	} outcome_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                       in_valid   = 1'b0;
	logic                       in_ready;
	logic                       kind       = KIND_LOAD;
	logic [INDEX_W-1:0]         coef_index = '0;
	logic signed [VALUE_W-1:0]  value      = '0;
	logic                       out_valid;
	logic                       out_ready  = 1'b0;
	logic signed [VALUE_W-1:0]  result;
	logic                       saturated;
	logic                       cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index  = '0;
	logic [CFG_W-1:0]           cfg_data   = '0;

	// shadow of the block's state and registers
	logic [VALUE_W-1:0]  coef_shadow [16];
	logic [DEGREE_W-1:0] deg_shadow;
	logic [MODE_W-1:0]   mode_shadow;
	logic [CFG_W-1:0]    level_shadow;

	word_t    word_queue [$];	// words waiting for the driver
	outcome_t expected_q [$];	// predicted result words, oldest first
	word_t    next_word;
	outcome_t head;

	logic quiet = 1'b0;	// no idling on either side
	int   in_gap, out_gap;
	int   cycle_count = 0;
	int   mismatches  = 0;
	int   n_words     = 0;
	int   n_checked   = 0;
	int   n_sat       = 0;
	int   n_settings  = 1;

	scaled_poly_eval_clip DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.coef_index (coef_index),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result     (result),
		.saturated  (saturated),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #10 clk = ~clk;

	// fixed-point product: magnitudes multiplied, truncated, saturated, sign restored
	function automatic logic signed [63:0] fx_product(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic [63:0]  ma, mb, mag;
		logic [127:0] full;
		ma   = a[63] ? -a : a;
		mb   = b[63] ? -b : b;
		full = ma * mb;
		full = full >> FRAC_BITS;
		mag  = (full > {64'd0, SAT_MAX}) ? SAT_MAX : full[63:0];
		return (a[63] ^ b[63]) ? -$signed(mag) : $signed(mag);
	endfunction

	// accumulator add with symmetric saturation
	function automatic logic signed [63:0] acc_add(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = a + b;
		if (s > BOUND65)
			return BOUND;
		if (s < -BOUND65)
			return -BOUND;
		return s[63:0];
	endfunction

	// applies one accepted word to the shadow and queues the result it causes
	task automatic model_word(input logic k, input logic [INDEX_W-1:0] idx,
			input logic [VALUE_W-1:0] v);
		logic signed [63:0] x, term, sum, res, lvl, ares, divisor, quot, recip;
		logic               sat;
		int                 i;
		if (k == KIND_LOAD) begin
			coef_shadow[idx] = v;
			return;
		end
		x    = $signed(v);
		term = 64'sd1 <<< FRAC_BITS;	// 1.0
		sum  = $signed(coef_shadow[0]);
		for (i = 1; i <= deg_shadow; i++) begin
			recip = (64'sd1 <<< FRAC_BITS) / i;
			term  = fx_product(fx_product(term, x), recip);
			sum   = acc_add(sum, fx_product($signed(coef_shadow[i]), term));
		end
		// squeeze the 64-bit sum into the 32-bit output range
		sat = 1'b0;
		if (sum > I32_HI) begin
			res = I32_HI;
			sat = 1'b1;
		end else if (sum < I32_LO) begin
			res = I32_LO;
			sat = 1'b1;
		end else begin
			res = sum;
		end
		lvl = $signed({33'd0, level_shadow});
		case (mode_shadow)
			CLIP_HARD: begin
				if (res >= lvl)
					res = lvl;
				else if (res <= -lvl)
					res = -lvl;
			end
			CLIP_SOFT: begin
				// res*L/(L+|res|), toward zero; zero divisor gives zero
				ares    = (res < 0) ? -res : res;
				divisor = lvl + ares;
				if (divisor == 0) begin
					res = 0;
				end else begin
					quot = (ares * lvl) / divisor;
					res  = (res < 0) ? -quot : quot;
				end
			end
			default: ;
		endcase
		if (sat)
			n_sat++;
		expected_q.push_back({res[31:0], sat});
	endtask

	// driver: presents queued words, with random idle bursts between them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			kind       <= KIND_LOAD;
			coef_index <= '0;
			value      <= '0;
			in_gap     <= 0;
		end else begin
			// word taken at this edge: predict from what was presented
			if (in_valid && in_ready)
				model_word(kind, coef_index, value);
			if (in_valid && !in_ready) begin
				// not taken yet, hold the word
			end else if (in_gap != 0) begin
				in_valid <= 1'b0;
				in_gap   <= in_gap - 1;
			end else if (word_queue.size() != 0 && !quiet && $urandom_range(0, 7) == 0) begin
				in_valid <= 1'b0;
				in_gap   <= $urandom_range(0, 10);
			end else if (word_queue.size() != 0) begin
				next_word = word_queue.pop_front();
				in_valid   <= 1'b1;
				kind       <= next_word.k;
				coef_index <= next_word.idx;
				value      <= next_word.v;
				n_words++;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: random backpressure on out_ready, checks each result word in order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_gap   <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: result word with nothing expected: result %h saturated %b",
						$time, result, saturated);
					mismatches++;
				end else begin
					head = expected_q.pop_front();
					if (result !== head.res) begin
						$display("%0t: result expected %h actual %h", $time, head.res, result);
						mismatches++;
					end
					if (saturated !== head.sat) begin
						$display("%0t: saturated expected %b actual %b",
							$time, head.sat, saturated);
						mismatches++;
					end
					n_checked++;
				end
			end
			if (out_gap != 0) begin
				out_ready <= 1'b0;
				out_gap   <= out_gap - 1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				out_gap   <= $urandom_range(0, 10);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_q.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic push_word(input logic k, input logic [INDEX_W-1:0] idx,
			input logic [VALUE_W-1:0] v);
		word_queue.push_back({k, idx, v});
	endtask

	// everything sent, every result back, then the longest evaluation time
	task automatic wait_idle();
		do
			@(negedge clk);
		while (word_queue.size() != 0 || in_valid || expected_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_DEGREE:     deg_shadow   = data[DEGREE_W-1:0];
			CFG_CLIP_MODE:  mode_shadow  = data[MODE_W-1:0];
			CFG_CLIP_LEVEL: level_shadow = data;
			default: ;
		endcase
	endtask

	// new register setting once the block is idle; junk fills unused data bits
	task automatic configure(input logic [DEGREE_W-1:0] deg, input logic [MODE_W-1:0] mode,
			input logic [CFG_W-1:0] lvl, input bit junk);
		logic [CFG_W-1:0] fill;
		fill = junk ? CFG_W'($urandom) : '0;
		wait_idle();
		write_reg(CFG_DEGREE, {fill[CFG_W-1:DEGREE_W], deg});
		write_reg(CFG_CLIP_MODE, {fill[CFG_W-1:MODE_W], mode});
		write_reg(CFG_CLIP_LEVEL, lvl);
		n_settings++;
	endtask

	function automatic logic [VALUE_W-1:0] pick_edge();
		case ($urandom_range(0, 4))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return 32'h0000_0000;
			3:       return 32'hFFFF_FFFF;
			default: return 32'h0001_0000;
		endcase
	endfunction

	// coefficients: mostly within +/-8.0, some full range and edge values
	function automatic logic [VALUE_W-1:0] pick_coef();
		case ($urandom_range(0, 9))
			0:       return pick_edge();
			1, 2, 3: return $urandom;
			default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
		endcase
	endfunction

	// x: mostly within +/-2.0 so higher powers stay in range
	function automatic logic [VALUE_W-1:0] pick_x();
		case ($urandom_range(0, 7))
			0:       return pick_edge();
			1:       return $urandom;
			default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_level();
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return 31'h7FFF_FFFF;
			2:       return CFG_W'($urandom_range(0, 32'h0004_0000));
			default: return CFG_W'($urandom);
		endcase
	endfunction

	initial begin
		int p, n;
		logic [DEGREE_W-1:0] deg;

		for (n = 0; n < 16; n++)
			coef_shadow[n] = '0;
		deg_shadow   = '0;
		mode_shadow  = CLIP_NONE;
		level_shadow = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset setting, degree 0, coefficient 0 at both extremes
		push_word(KIND_LOAD, 4'd0, 32'h7FFF_FFFF);
		push_word(KIND_EVAL, 4'd0, 32'h0000_0000);
		push_word(KIND_LOAD, 4'd0, 32'h8000_0000);
		push_word(KIND_EVAL, 4'd0, 32'h7FFF_FFFF);
		push_word(KIND_EVAL, 4'd0, 32'h8000_0000);

		// soft clip at level zero: zero divisor on an all-zero polynomial,
		// then a huge saturating one that still comes out zero
		configure(4'd15, CLIP_SOFT, '0, 1'b0);
		push_word(KIND_LOAD, 4'd0, 32'h0000_0000);
		push_word(KIND_EVAL, 4'd0, 32'h1234_5678);
		push_word(KIND_LOAD, 4'd15, 32'h7FFF_FFFF);
		push_word(KIND_LOAD, 4'd1, 32'h8000_0000);
		push_word(KIND_EVAL, 4'd0, 32'h7FFF_FFFF);

		// full degree, hard clip at the largest level: intermediate overflow
		// and output saturation in both directions
		configure(4'd15, CLIP_HARD, 31'h7FFF_FFFF, 1'b0);
		push_word(KIND_EVAL, 4'd0, 32'h7FFF_FFFF);
		push_word(KIND_EVAL, 4'd0, 32'h8000_0000);
		push_word(KIND_EVAL, 4'd0, 32'h0001_0000);
		push_word(KIND_EVAL, 4'd0, 32'hFFFF_0000);

		// unused clip mode behaves as no clipping
		configure(4'd2, CLIP_UNUSED, 31'h0001_0000, 1'b0);
		push_word(KIND_LOAD, 4'd2, 32'h0001_0000);
		push_word(KIND_EVAL, 4'd0, 32'hFFFF_FFFF);
		push_word(KIND_EVAL, 4'd0, 32'h0002_0000);

		// hard clip at level zero pins everything to zero
		configure(4'd1, CLIP_HARD, '0, 1'b0);
		push_word(KIND_LOAD, 4'd0, 32'h0000_8000);
		push_word(KIND_EVAL, 4'd0, 32'h0000_0000);
		push_word(KIND_EVAL, 4'd0, 32'h8000_0000);

		// soft clip at the largest level
		configure(4'd15, CLIP_SOFT, 31'h7FFF_FFFF, 1'b0);
		push_word(KIND_LOAD, 4'd3, 32'hFFFF_0000);
		push_word(KIND_EVAL, 4'd0, 32'h7FFF_FFFF);
		push_word(KIND_EVAL, 4'd0, 32'h0001_8000);

		// random phases, mostly low degree; the last one runs without idling
		for (p = 0; p < 12; p++) begin
			if ($urandom_range(0, 3) == 0 || p == 2 || p == 11)
				deg = (p == 2 || p == 11) ? 4'd15 : DEGREE_W'($urandom_range(5, 15));
			else
				deg = DEGREE_W'($urandom_range(0, 4));
			configure(deg, MODE_W'($urandom_range(0, 3)), pick_level(),
				1'($urandom_range(0, 1)));
			if (p == 11)
				quiet = 1'b1;
			for (n = 0; n < 57; n++) begin
				if ($urandom_range(0, 9) < 3)
					push_word(KIND_LOAD, INDEX_W'($urandom_range(0, 15)), pick_coef());
				else
					push_word(KIND_EVAL, INDEX_W'($urandom_range(0, 15)), pick_x());
			end
		end

		wait_idle();
		$display("sent %0d words under %0d register settings", n_words, n_settings);
		$display("checked %0d results, %0d of them saturated", n_checked, n_sat);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
